// ===== hdl/ilc_pkg.sv =====
// ----------------------------------------------------------------------------
// ilc_pkg: shared types and constants of the integer literal converter
// Mode codes, error codes, radix selects and the front-to-back request.
// ----------------------------------------------------------------------------
package ilc_pkg;

   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 64;
   localparam int ERR_W   = 2;
   localparam int CNT_W   = 5;
   localparam int DIGIT_W = 4;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(20);

   // front-to-back queue
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_LONG  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_DIGIT = 2'd2;

   localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

   typedef enum logic [2:0] {
      MODE_START = 3'd0,
      MODE_ZERO  = 3'd1,
      MODE_DEC   = 3'd2,
      MODE_OCT   = 3'd3,
      MODE_HEX   = 3'd4,
      MODE_BIN   = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2,
      RADIX_BIN = 2'd3
   } radix_type;

   // one classified character, front to back
   typedef struct packed {
      logic                take;      // character is a digit position
      logic                digit_ok;  // valid digit for the radix
      logic [DIGIT_W-1:0]  digit;
      radix_type           radix;
      logic                last;
      logic                too_long;
   } op_type;

   // digit value of a character, bit DIGIT_W set when it is a hex digit at all
   function automatic logic [DIGIT_W:0] hex_digit(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] lc;
      logic [CHAR_W-1:0] d;
      lc = c | CASE_BIT;
      hex_digit = '0;
      if (c >= "0" && c <= "9") begin
         d = c - CHAR_W'("0");
         hex_digit = {1'b1, d[DIGIT_W-1:0]};
      end else if (lc >= "a" && lc <= "f") begin
         d = lc - CHAR_W'("a") + CHAR_W'(10);
         hex_digit = {1'b1, d[DIGIT_W-1:0]};
      end
   endfunction

endpackage

// ===== hdl/ilc_front.sv =====
// ----------------------------------------------------------------------------
// ilc_front: prefix tracking and character classification
// Follows the radix prefix and the length, and turns each character into a
// request for the accumulator stage.
// ----------------------------------------------------------------------------
module ilc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [ilc_pkg::CHAR_W-1:0] in_char,
   input  logic                      in_last,
   output ilc_pkg::op_type           op
);

   ilc_pkg::mode_type             mode_ff, mode_in;
   logic [ilc_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [ilc_pkg::CNT_W-1:0]     count_inc;
   logic [ilc_pkg::DIGIT_W:0]     hd;
   logic [ilc_pkg::CHAR_W-1:0]    lc;
   ilc_pkg::radix_type            radix;
   logic                          take;
   logic                          in_range;

   assign hd = ilc_pkg::hex_digit(in_char);
   assign lc = in_char | ilc_pkg::CASE_BIT;
   assign count_inc = (count_ff < ilc_pkg::CNT_MAX) ? count_ff + 1'b1 : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ilc_pkg::MODE_START;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      take     = 1'b1;
      radix    = ilc_pkg::RADIX_DEC;
      unique case (mode_ff)
         ilc_pkg::MODE_START: begin
            if (in_char == "0") begin
               mode_in = ilc_pkg::MODE_ZERO;
               take    = 1'b0;
            end else begin
               mode_in = ilc_pkg::MODE_DEC;
            end
         end
         ilc_pkg::MODE_ZERO: begin
            radix = ilc_pkg::RADIX_OCT;
            if (lc == "x") begin
               mode_in = ilc_pkg::MODE_HEX;
               take    = 1'b0;
            end else if (lc == "b") begin
               mode_in = ilc_pkg::MODE_BIN;
               take    = 1'b0;
            end else begin
               mode_in = ilc_pkg::MODE_OCT;
            end
         end
         ilc_pkg::MODE_OCT: radix = ilc_pkg::RADIX_OCT;
         ilc_pkg::MODE_HEX: radix = ilc_pkg::RADIX_HEX;
         ilc_pkg::MODE_BIN: radix = ilc_pkg::RADIX_BIN;
         default:           radix = ilc_pkg::RADIX_DEC;
      endcase
      if (in_valid) begin
         count_in = count_inc;
         if (in_last) begin
            mode_in  = ilc_pkg::MODE_START;
            count_in = '0;
         end
      end else begin
         mode_in = mode_ff;
      end
   end

   always_comb begin
      unique case (radix)
         ilc_pkg::RADIX_DEC: in_range = hd[ilc_pkg::DIGIT_W-1:0] < 4'd10;
         ilc_pkg::RADIX_OCT: in_range = hd[ilc_pkg::DIGIT_W-1:0] < 4'd8;
         ilc_pkg::RADIX_BIN: in_range = hd[ilc_pkg::DIGIT_W-1:0] < 4'd2;
         default:            in_range = 1'b1;
      endcase
   end

   assign op.take     = take;
   assign op.digit_ok = hd[ilc_pkg::DIGIT_W] & in_range;
   assign op.digit    = hd[ilc_pkg::DIGIT_W-1:0];
   assign op.radix    = radix;
   assign op.last     = in_last;
   assign op.too_long = count_inc > ilc_pkg::MAX_LEN;

endmodule

// ===== hdl/ilc_queue.sv =====
// ----------------------------------------------------------------------------
// ilc_queue: short request queue between front and back
// Registered full and empty, so neither side sees the other's handshake.
// ----------------------------------------------------------------------------
module ilc_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  ilc_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output ilc_pkg::op_type pop_op,
   output logic            empty
);

   ilc_pkg::op_type                 slot_ff [ilc_pkg::Q_DEPTH];
   logic [ilc_pkg::Q_PTR_W-1:0]     wr_ff, wr_in;
   logic [ilc_pkg::Q_PTR_W-1:0]     rd_ff, rd_in;
   logic [ilc_pkg::Q_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                            do_push, do_pop;

   localparam logic [ilc_pkg::Q_PTR_W-1:0] LAST_PTR = ilc_pkg::Q_PTR_W'(ilc_pkg::Q_DEPTH - 1);
   localparam logic [ilc_pkg::Q_CNT_W-1:0] FULL_CNT = ilc_pkg::Q_CNT_W'(ilc_pkg::Q_DEPTH);

   assign full    = cnt_ff == FULL_CNT;
   assign empty   = cnt_ff == '0;
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign pop_op  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop)      cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_op;
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("queue count over depth");
   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count missed a push");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || cnt_ff == FULL_CNT) |-> wr_ff == rd_ff)
      else $error("queue pointers out of step");
`endif

endmodule

// ===== hdl/ilc_back.sv =====
// ----------------------------------------------------------------------------
// ilc_back: accumulator and result register
// Applies acc = acc * radix + digit with shift-and-add and holds the result
// until it is taken.
// ----------------------------------------------------------------------------
module ilc_back (
   input  logic                             clock,
   input  logic                             reset,
   input  ilc_pkg::op_type                  op,
   input  logic                             op_valid,
   output logic                             op_take,
   output logic                             res_valid,
   input  logic                             res_pop,
   output logic [ilc_pkg::VALUE_W-1:0]      res_value,
   output logic [ilc_pkg::ERR_W-1:0]        res_error
);

   logic [ilc_pkg::VALUE_W-1:0] acc_ff, acc_in;
   logic [ilc_pkg::ERR_W-1:0]   err_ff, err_in;
   logic                        res_valid_ff, res_valid_in;
   logic [ilc_pkg::VALUE_W-1:0] res_value_ff, res_value_in;
   logic [ilc_pkg::ERR_W-1:0]   res_error_ff, res_error_in;
   logic [ilc_pkg::VALUE_W-1:0] acc_mul, acc_upd;
   logic [ilc_pkg::ERR_W-1:0]   err_upd;

   assign op_take = op_valid & (~res_valid_ff | res_pop);

   always_comb begin
      unique case (op.radix)
         ilc_pkg::RADIX_DEC: acc_mul = (acc_ff << 3) + (acc_ff << 1);
         ilc_pkg::RADIX_OCT: acc_mul = acc_ff << 3;
         ilc_pkg::RADIX_HEX: acc_mul = acc_ff << 4;
         default:            acc_mul = acc_ff << 1;
      endcase
   end

   always_comb begin
      acc_upd = acc_ff;
      err_upd = err_ff;
      if (op.take) begin
         if (op.digit_ok) acc_upd = acc_mul + ilc_pkg::VALUE_W'(op.digit);
         else             err_upd = ilc_pkg::ERR_DIGIT;
      end

      acc_in       = acc_ff;
      err_in       = err_ff;
      res_valid_in = res_valid_ff & ~res_pop;
      res_value_in = res_value_ff;
      res_error_in = res_error_ff;
      if (op_take) begin
         if (op.last) begin
            acc_in       = '0;
            err_in       = ilc_pkg::ERR_NONE;
            res_valid_in = 1'b1;
            res_value_in = acc_upd;
            res_error_in = op.too_long ? ilc_pkg::ERR_LONG : err_upd;
         end else begin
            acc_in = acc_upd;
            err_in = err_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         err_ff       <= ilc_pkg::ERR_NONE;
         res_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         err_ff       <= err_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_value_ff <= res_value_in;
      res_error_ff <= res_error_in;
   end

   assign res_valid = res_valid_ff;
   assign res_value = res_value_ff;
   assign res_error = res_error_ff;

`ifndef SYNTHESIS
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      err_ff == ilc_pkg::ERR_NONE || err_ff == ilc_pkg::ERR_DIGIT)
      else $error("sticky error holds a bad code");
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (op_take && op.last) |=> (acc_ff == '0 && err_ff == ilc_pkg::ERR_NONE))
      else $error("accumulator not cleared after last character");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && !res_pop) |-> !op_take)
      else $error("result register overwritten while waiting");
`endif

endmodule

// ===== hdl/integer_literal_converter.sv =====
// ----------------------------------------------------------------------------
// integer_literal_converter: C integer literal to 64-bit value
// Characters come in one per request; the last one yields value and error.
//
//   channel   ports                                   handshake
//   request   req_character, req_last_char            req_push / req_full
//   response  rsp_value, rsp_error                    rsp_empty / rsp_pop
//
// One character per cycle sustained while no result waits unpopped; the
// accumulator update in the back stage (one 64-bit shift-and-add per cycle) sets that rate.
// A last character is registered in a queue slot and then in the result register
// before it shows up on the response ports.
// Reset clears prefix state, length count, accumulator, the request queue and the result valid flag.
// req_full rises only when the two-entry queue fills behind a held response.
// ----------------------------------------------------------------------------
module integer_literal_converter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [ilc_pkg::CHAR_W-1:0]         req_character,
   input  logic                               req_last_char,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [ilc_pkg::VALUE_W-1:0] rsp_value,
   output logic [ilc_pkg::ERR_W-1:0]          rsp_error
);

   ilc_pkg::op_type             front_op, back_op;
   logic                        accept;
   logic                        q_empty;
   logic                        back_take;
   logic                        res_valid;
   logic [ilc_pkg::VALUE_W-1:0] res_value;

   assign accept = req_push & ~req_full;

   ilc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_char  (req_character),
      .in_last  (req_last_char),
      .op       (front_op)
   );

   ilc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .push_op (front_op),
      .full    (req_full),
      .pop     (back_take),
      .pop_op  (back_op),
      .empty   (q_empty)
   );

   ilc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op        (back_op),
      .op_valid  (~q_empty),
      .op_take   (back_take),
      .res_valid (res_valid),
      .res_pop   (rsp_pop),
      .res_value (res_value),
      .res_error (rsp_error)
   );

   assign rsp_empty = ~res_valid;
   assign rsp_value = signed'(res_value);

endmodule

// ===== tb/literal_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// literal_check_pkg: expected conversions for the integer literal converter
// Tracks prefix, length and running value per accepted character and keeps
// the converted literals in order until the responses arrive.
// ----------------------------------------------------------------------------
package literal_check_pkg;
   import ilc_pkg::*;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic [ERR_W-1:0]   error;
   } conversion_type;

   class literal_tracker;
      logic [CNT_W-1:0]   seen_count;
      mode_type           prefix_mode;
      logic [VALUE_W-1:0] running_value;
      logic [ERR_W-1:0]   digit_fault;
      conversion_type     due_values[$];
      int                 mismatches;

      function new();
         clear_literal();
         mismatches = 0;
      endfunction

      function void clear_literal();
         seen_count    = '0;
         prefix_mode   = MODE_START;
         running_value = '0;
         digit_fault   = ERR_NONE;
      endfunction

      // non-digits of the radix are skipped but leave a sticky fault
      function void add_digit(logic [CHAR_W-1:0] c, int radix);
         logic [CHAR_W-1:0] lc;
         int                d;
         lc = c | CASE_BIT;
         d = -1;
         if (c >= "0" && c <= "9") begin
            d = int'(c) - int'("0");
         end else if (lc >= "a" && lc <= "f") begin
            d = int'(lc) - int'("a") + 10;
         end
         if (d >= radix) begin
            d = -1;
         end
         if (d < 0) begin
            digit_fault = ERR_DIGIT;
         end else begin
            running_value = running_value * VALUE_W'(radix) + VALUE_W'(d);
         end
      endfunction

      function void take_char(logic [CHAR_W-1:0] c, logic last);
         logic [CHAR_W-1:0] lc;
         conversion_type    done;
         lc = c | CASE_BIT;
         if (seen_count != CNT_MAX) begin
            seen_count++;
         end
         case (prefix_mode)
            MODE_START: begin
               if (c == "0") begin
                  prefix_mode   = MODE_ZERO;
                  running_value = '0;
               end else begin
                  prefix_mode = MODE_DEC;
                  add_digit(c, 10);
               end
            end
            MODE_ZERO: begin
               if (lc == "x") begin
                  prefix_mode = MODE_HEX;
               end else if (lc == "b") begin
                  prefix_mode = MODE_BIN;
               end else begin
                  prefix_mode = MODE_OCT;
                  add_digit(c, 8);
               end
            end
            MODE_OCT: add_digit(c, 8);
            MODE_HEX: add_digit(c, 16);
            MODE_BIN: add_digit(c, 2);
            default:  add_digit(c, 10);
         endcase
         if (last) begin
            done.value = running_value;
            done.error = (seen_count > MAX_LEN) ? ERR_LONG : digit_fault;
            due_values.push_back(done);
            clear_literal();
         end
      endfunction

      function void check_result(logic [VALUE_W-1:0] value, logic [ERR_W-1:0] error);
         conversion_type want;
         if (due_values.size() == 0) begin
            $error("response with no literal pending: value %0h error %0d", value, error);
            mismatches++;
            return;
         end
         want = due_values.pop_front();
         if (value !== want.value) begin
            $error("value: expected %0h, got %0h", want.value, value);
            mismatches++;
         end
         if (error !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, error);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return due_values.size();
      endfunction
   endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression for the integer literal converter
// Sends directed and random C integer literals character by character in
// bursts, pops responses on a shifting stall pattern and compares each one
// with the value and error code tracked for the literal.
// ----------------------------------------------------------------------------
module tb_top;
   import ilc_pkg::*;
   import literal_check_pkg::*;

   localparam int TOTAL_CHARS  = 1300;
   localparam int LONG_HOLD    = 200;
   localparam int SETTLE       = 8;
   localparam int LIMIT_CYCLES = 400000;

   typedef logic [CHAR_W-1:0] char_q_type[$];

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic [CHAR_W-1:0]         req_character = '0;
   logic                      req_last_char = 1'b0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic signed [VALUE_W-1:0] rsp_value;
   logic [ERR_W-1:0]          rsp_error;

   literal_tracker book = new();
   bit             push_on = 0;
   bit             hold_request = 0;
   int             burst_left = 1;
   int             sent_chars = 0;
   int             cycles = 0;

   integer_literal_converter dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_character (req_character),
      .req_last_char (req_last_char),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_value     (rsp_value),
      .rsp_error     (rsp_error)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("integer_literal_converter regression: fail");
      $finish;
   end

   task automatic pause_requests(int n);
      if (push_on) begin
         req_push <= 1'b0;
         push_on = 0;
      end
      repeat (n) @(posedge clock);
   endtask

   task automatic send_char(logic [CHAR_W-1:0] c, logic last);
      req_push      <= 1'b1;
      push_on       = 1;
      req_character <= c;
      req_last_char <= last;
      do @(posedge clock); while (req_full);
      book.take_char(c, last);
      sent_chars++;
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
         pause_requests($urandom_range(1, 6));
      end
   endtask

   task automatic send_literal(char_q_type lit);
      foreach (lit[i]) begin
         send_char(lit[i], i == lit.size() - 1);
      end
   endtask

   task automatic send_text(string s);
      char_q_type lit;
      for (int i = 0; i < s.len(); i++) begin
         lit.push_back(s[i]);
      end
      send_literal(lit);
   endtask

   // stop sending until every converted literal has come back
   task automatic drain_requests();
      pause_requests(0);
      while (book.outstanding() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic char_q_type random_literal();
      char_q_type lit;
      int         kind;
      int         pick;
      int         len;
      int         v;
      kind = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      len = (pick < 82) ? $urandom_range(1, 12) :
            (pick < 97) ? $urandom_range(13, 22) : $urandom_range(23, 36);
      if (kind < 25 || (kind >= 78 && kind < 84)) begin
         lit.push_back(CHAR_W'("1" + $urandom_range(0, 8)));
         repeat (len - 1) lit.push_back(CHAR_W'("0" + $urandom_range(0, 9)));
      end else if (kind < 45 || (kind >= 84 && kind < 90)) begin
         lit.push_back("0");
         lit.push_back($urandom_range(0, 1) ? "x" : "X");
         repeat (len) begin
            v = $urandom_range(0, 15);
            if (v < 10) begin
               lit.push_back(CHAR_W'("0" + v));
            end else begin
               lit.push_back(CHAR_W'(($urandom_range(0, 1) ? "A" : "a") + v - 10));
            end
         end
      end else if (kind < 60) begin
         lit.push_back("0");
         lit.push_back($urandom_range(0, 1) ? "b" : "B");
         repeat (len) lit.push_back($urandom_range(0, 1) ? "1" : "0");
      end else if (kind < 75) begin
         lit.push_back("0");
         repeat (len) lit.push_back(CHAR_W'("0" + $urandom_range(0, 7)));
      end else if (kind < 78) begin
         lit.push_back("0");
         case ($urandom_range(0, 4))
            0: lit.push_back("x");
            1: lit.push_back("X");
            2: lit.push_back("b");
            3: lit.push_back("B");
            default: ;
         endcase
      end else begin
         repeat (len) lit.push_back(CHAR_W'($urandom_range(0, 255)));
      end
      // well-formed literal with one stray character
      if (kind >= 78 && kind < 90) begin
         lit[$urandom_range(0, lit.size() - 1)] = CHAR_W'($urandom_range(0, 255));
      end
      return lit;
   endfunction

   initial begin
      int  pop_mode;
      int  mode_left;
      int  hold_left;
      pop_mode  = 0;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            book.check_result(rsp_value, rsp_error);
         end
         if (hold_request) begin
            hold_request = 0;
            hold_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            pop_mode  = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (pop_mode)
               0:       rsp_pop <= 1'b1;
               1:       rsp_pop <= ($urandom_range(0, 3) != 0);
               default: rsp_pop <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      bit stress_done;
      stress_done = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_text("0");
      send_text("7");
      send_text("0x");
      send_text("0B");
      send_text("0xFFFFFFFFFFFFFFFF");
      send_text("0XfFaB09");
      send_text("0b1011");
      send_text("0777");
      send_text("089");
      send_text("0x1g2");
      send_text("12a3");
      send_text("18446744073709551615");
      send_text("18446744073709551616");
      send_text("123456789012345678901");
      send_text("0x1234567890abcdefgh1");
      send_text("0b2");
      send_text("-5");
      send_text("0b111111111111111111111111111111111");
      send_literal('{8'hFF});
      send_literal('{8'h00});
      send_literal('{8'h30, 8'hD8, 8'h80});
      drain_requests();

      while (sent_chars < TOTAL_CHARS) begin
         if (!stress_done && sent_chars > TOTAL_CHARS / 2) begin
            stress_done = 1;
            drain_requests();
            // receiver holds off while requests keep coming back to back
            hold_request = 1;
            burst_left = 1000;
            repeat (16) send_literal(random_literal());
            burst_left = 1;
            drain_requests();
         end
         send_literal(random_literal());
      end

      drain_requests();
      if (book.mismatches == 0 && book.outstanding() == 0) begin
         $display("integer_literal_converter regression: pass");
      end else begin
         $display("integer_literal_converter regression: fail");
      end
      $finish;
   end

endmodule
